// ----- rtl/arlt_pkg.sv -----
// Shared constants and types for the allocated-region lookup table.
package arlt_pkg;

    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int DEF_ADDRESS_BITS  = 48;
    localparam int SIZE_BITS         = 32;

    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

// ----- rtl/arlt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module arlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/alloc_range_lookup_table_core.sv -----
// Top level of the allocated-region lookup table.
//
// Input channel (s_*): one request per handshake. s_action selects a record
// (store base s_address with size s_alloc_size) or a lookup (find the first
// slot, in slot order, whose inclusive range base..base+size holds s_address).
// Output channel (m_*): exactly one result per request, in request order.
// A lookup reports found, region start and length; a record reports
// m_table_full when a new base found no free slot and was dropped.
// Slots live in one RAM with a registered read; a request walks the filled
// slots one per cycle and stops at the first match. One request is in work
// at a time. The result sits in an output register; s_ready returns high
// as soon as that register is loaded, so the next request is taken while
// the result waits. If the receiver stalls with a result still held, the
// next request finishes its walk and holds until the register frees.
// Reset clears the fill count, so the table starts empty with no clearing pass.
module alloc_range_lookup_table_core #(
    parameter int TABLE_ENTRIES = arlt_pkg::DEF_TABLE_ENTRIES,
    parameter int ADDRESS_BITS  = arlt_pkg::DEF_ADDRESS_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [ADDRESS_BITS-1:0]       s_address,
    input  logic [arlt_pkg::SIZE_BITS-1:0] s_alloc_size,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [ADDRESS_BITS-1:0]       m_region_start,
    output logic [arlt_pkg::SIZE_BITS-1:0] m_region_length,
    output logic                          m_table_full
);

    localparam int SIZE_BITS = arlt_pkg::SIZE_BITS;
    localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ENTRY_W   = ADDRESS_BITS + SIZE_BITS;

    arlt_pkg::state_t state_reg, state_next;

    logic                    req_action_reg, req_action_next;
    logic [ADDRESS_BITS-1:0] req_addr_reg, req_addr_next;
    logic [SIZE_BITS-1:0]    req_size_reg, req_size_next;
    logic [CNT_W-1:0]        rd_cnt_reg, rd_cnt_next;
    logic                    cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]        cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0]        used_reg, used_next;

    logic                    res_found_reg, res_found_next;
    logic [ADDRESS_BITS-1:0] res_start_reg, res_start_next;
    logic [SIZE_BITS-1:0]    res_length_reg, res_length_next;
    logic                    res_full_reg, res_full_next;

    logic                    m_valid_reg, m_valid_next;
    logic                    m_found_reg, m_found_next;
    logic [ADDRESS_BITS-1:0] m_start_reg, m_start_next;
    logic [SIZE_BITS-1:0]    m_length_reg, m_length_next;
    logic                    m_full_reg, m_full_next;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [ENTRY_W-1:0]      ram_rdata;

    logic [ADDRESS_BITS-1:0] rd_base;
    logic [SIZE_BITS-1:0]    rd_size;
    logic [ADDRESS_BITS-1:0] addr_diff;
    logic                    lookup_match;
    logic                    record_match;
    logic                    entry_match;
    logic                    scan_hit;
    logic                    scan_miss;
    logic                    scan_issue;
    logic                    has_room;
    logic                    out_free;

    arlt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_slot_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(rd_cnt_reg[IDX_W-1:0]),
        .rdata(ram_rdata)
    );

    assign rd_base      = ram_rdata[ENTRY_W-1 -: ADDRESS_BITS];
    assign rd_size      = ram_rdata[SIZE_BITS-1:0];
    assign addr_diff    = req_addr_reg - rd_base;
    assign lookup_match = (rd_base <= req_addr_reg) && (addr_diff <= ADDRESS_BITS'(rd_size));
    assign record_match = (rd_base == req_addr_reg);
    assign entry_match  = (req_action_reg == arlt_pkg::ACT_LOOKUP) ? lookup_match : record_match;

    assign scan_hit   = (state_reg == arlt_pkg::ST_SCAN) && cmp_valid_reg && entry_match;
    assign scan_miss  = (state_reg == arlt_pkg::ST_SCAN) && !cmp_valid_reg
                        && (rd_cnt_reg == used_reg);
    assign scan_issue = (state_reg == arlt_pkg::ST_SCAN) && (rd_cnt_reg < used_reg) && !scan_hit;
    assign has_room   = (used_reg < CNT_W'(TABLE_ENTRIES));
    assign out_free   = !m_valid_reg || m_ready;

    assign s_ready         = (state_reg == arlt_pkg::ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_found         = m_found_reg;
    assign m_region_start  = m_start_reg;
    assign m_region_length = m_length_reg;
    assign m_table_full    = m_full_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            arlt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = arlt_pkg::ST_SCAN;
                end
            end
            arlt_pkg::ST_SCAN: begin
                if (scan_hit || scan_miss) begin
                    state_next = arlt_pkg::ST_FINISH;
                end
            end
            arlt_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = arlt_pkg::ST_IDLE;
                end
            end
            default: state_next = arlt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        req_action_next = req_action_reg;
        req_addr_next   = req_addr_reg;
        req_size_next   = req_size_reg;
        rd_cnt_next     = rd_cnt_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        used_next       = used_reg;
        res_found_next  = res_found_reg;
        res_start_next  = res_start_reg;
        res_length_next = res_length_reg;
        res_full_next   = res_full_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_found_next    = m_found_reg;
        m_start_next    = m_start_reg;
        m_length_next   = m_length_reg;
        m_full_next     = m_full_reg;
        ram_we          = 1'b0;
        ram_waddr       = cmp_idx_reg;
        ram_wdata       = {req_addr_reg, req_size_reg};

        unique case (state_reg)
            arlt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    req_action_next = s_action;
                    req_addr_next   = s_address;
                    req_size_next   = s_alloc_size;
                    rd_cnt_next     = '0;
                end
            end
            arlt_pkg::ST_SCAN: begin
                if (scan_issue) begin
                    rd_cnt_next    = rd_cnt_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_cnt_reg[IDX_W-1:0];
                end
                if (scan_hit || scan_miss) begin
                    res_found_next  = 1'b0;
                    res_start_next  = '0;
                    res_length_next = '0;
                    res_full_next   = 1'b0;
                end
                if (scan_hit) begin
                    if (req_action_reg == arlt_pkg::ACT_LOOKUP) begin
                        res_found_next  = 1'b1;
                        res_start_next  = rd_base;
                        res_length_next = rd_size;
                    end else begin
                        ram_we = 1'b1;
                    end
                end else if (scan_miss && (req_action_reg == arlt_pkg::ACT_RECORD)) begin
                    if (has_room) begin
                        ram_we    = 1'b1;
                        ram_waddr = used_reg[IDX_W-1:0];
                        used_next = used_reg + CNT_W'(1);
                    end else begin
                        res_full_next = 1'b1;
                    end
                end
            end
            arlt_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_found_next  = res_found_reg;
                    m_start_next  = res_start_reg;
                    m_length_next = res_length_reg;
                    m_full_next   = res_full_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= arlt_pkg::ST_IDLE;
            used_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_action_reg <= req_action_next;
        req_addr_reg   <= req_addr_next;
        req_size_reg   <= req_size_next;
        rd_cnt_reg     <= rd_cnt_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_found_reg  <= res_found_next;
        res_start_reg  <= res_start_next;
        res_length_reg <= res_length_next;
        res_full_reg   <= res_full_next;
        m_found_reg    <= m_found_next;
        m_start_reg    <= m_start_next;
        m_length_reg   <= m_length_next;
        m_full_reg     <= m_full_next;
    end

endmodule

// ----- rtl/arlt_checker.sv -----
// Port-level checks for the allocated-region lookup table, bound to the top level.
module arlt_checker #(
    parameter int ADDRESS_BITS = arlt_pkg::DEF_ADDRESS_BITS
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_found,
    input logic [ADDRESS_BITS-1:0]        m_region_start,
    input logic [arlt_pkg::SIZE_BITS-1:0] m_region_length,
    input logic                           m_table_full
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_region_start)
            && $stable(m_region_length) && $stable(m_table_full))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("new request taken while one is in work");

    a_found_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> !m_table_full)
        else $error("lookup hit flagged as dropped record");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> (m_region_start == '0) && (m_region_length == '0))
        else $error("nonzero region on a miss");

endmodule

bind alloc_range_lookup_table_core arlt_checker #(
    .ADDRESS_BITS(ADDRESS_BITS)
) u_arlt_checker (.*);

// ----- verif/alloc_range_lookup_table_core_test.sv -----
// Self-checking testbench for the allocated-region lookup table core.
module alloc_range_lookup_table_core_test;

    localparam int ENTRIES = arlt_pkg::DEF_TABLE_ENTRIES;
    localparam int ADDR_W  = arlt_pkg::DEF_ADDRESS_BITS;
    localparam int SIZE_W  = arlt_pkg::SIZE_BITS;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] length;
        logic              full;
    } region_result_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_action;
    logic [ADDR_W-1:0] s_address;
    logic [SIZE_W-1:0] s_alloc_size;
    logic              m_valid;
    logic              m_ready;
    logic              m_found;
    logic [ADDR_W-1:0] m_region_start;
    logic [SIZE_W-1:0] m_region_length;
    logic              m_table_full;

    // Table image kept alongside the block; slots below used_count are valid.
    logic [ADDR_W-1:0] slot_start [ENTRIES];
    logic [SIZE_W-1:0] slot_len [ENTRIES];
    int                used_count = 0;

    region_result_t    pending_results [$];
    int                mismatches = 0;
    bit                src_idle = 1'b1;
    bit                sink_idle = 1'b1;
    int                sink_hold = 0;

    alloc_range_lookup_table_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_address       (s_address),
        .s_alloc_size    (s_alloc_size),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_found         (m_found),
        .m_region_start  (m_region_start),
        .m_region_length (m_region_length),
        .m_table_full    (m_table_full)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("alloc_range_lookup_table_core: mismatch");
        $finish;
    end

    function automatic region_result_t apply_request(input logic act,
                                                     input logic [ADDR_W-1:0] addr,
                                                     input logic [SIZE_W-1:0] sz);
        region_result_t res;
        int             hit;
        logic [ADDR_W:0] last;
        res = '0;
        hit = -1;
        if (act == arlt_pkg::ACT_RECORD) begin
            for (int i = 0; i < used_count; i++)
                if (hit < 0 && slot_start[i] == addr)
                    hit = i;
            if (hit >= 0) begin
                slot_len[hit] = sz;
            end else if (used_count < ENTRIES) begin
                slot_start[used_count] = addr;
                slot_len[used_count] = sz;
                used_count++;
            end else begin
                res.full = 1'b1;
            end
        end else begin
            for (int i = 0; i < used_count; i++) begin
                last = slot_start[i] + slot_len[i];
                if (hit < 0 && addr >= slot_start[i] && {1'b0, addr} <= last)
                    hit = i;
            end
            if (hit >= 0) begin
                res.found = 1'b1;
                res.start = slot_start[hit];
                res.length = slot_len[hit];
            end
        end
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] random_base();
        logic [63:0] r;
        r = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 0)
            return r[ADDR_W-1:0];
        return (ADDR_W'($urandom_range(0, 3)) << 44) | ADDR_W'($urandom_range(0, 'hFFFFF));
    endfunction

    function automatic logic [SIZE_W-1:0] random_size();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return $urandom_range(0, 'hFFF);
        if (pick < 9)
            return $urandom_range(0, 'hFFFFF);
        return $urandom;
    endfunction

    task automatic issue_request(input logic act, input logic [ADDR_W-1:0] addr,
                                 input logic [SIZE_W-1:0] sz);
        int gap;
        gap = src_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_address <= addr;
        s_alloc_size <= sz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(apply_request(act, addr, sz));
    endtask

    task automatic random_request(input int new_pct);
        int pick;
        int k;
        logic [ADDR_W-1:0] addr;
        logic [63:0] span;
        pick = $urandom_range(0, 99);
        k = (used_count > 0) ? $urandom_range(0, used_count - 1) : 0;
        if (pick < new_pct || used_count == 0 && pick < 45) begin
            issue_request(arlt_pkg::ACT_RECORD, random_base(), random_size());
        end else if (pick < new_pct + 15) begin
            issue_request(arlt_pkg::ACT_RECORD, slot_start[k], random_size());
        end else if (pick < 85 && used_count > 0) begin
            span = {32'b0, slot_len[k]} + 64'd1;
            case ($urandom_range(0, 4))
                0: addr = slot_start[k];
                1: addr = slot_start[k] + slot_len[k];
                2: addr = slot_start[k] + slot_len[k] + 1;
                3: addr = slot_start[k] - 1;
                default: addr = slot_start[k] + ADDR_W'({32'b0, $urandom} % span);
            endcase
            issue_request(arlt_pkg::ACT_LOOKUP, addr, random_size());
        end else begin
            issue_request(arlt_pkg::ACT_LOOKUP, random_base(), random_size());
        end
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_empty_lookups();
        issue_request(arlt_pkg::ACT_LOOKUP, '0, '0);
        issue_request(arlt_pkg::ACT_LOOKUP, '1, '1);
    endtask

    task automatic test_extremes();
        issue_request(arlt_pkg::ACT_RECORD, '0, '0);
        issue_request(arlt_pkg::ACT_LOOKUP, '0, '0);
        issue_request(arlt_pkg::ACT_LOOKUP, 48'h1, '0);
        issue_request(arlt_pkg::ACT_RECORD, 48'hFFFF_FFFF_FFF0, '1);
        issue_request(arlt_pkg::ACT_LOOKUP, '1, '0);
        issue_request(arlt_pkg::ACT_LOOKUP, 48'hFFFF_FFFF_FFEF, '0);
    endtask

    task automatic test_same_base();
        issue_request(arlt_pkg::ACT_RECORD, 48'h1000, 32'h100);
        issue_request(arlt_pkg::ACT_LOOKUP, 48'h1000, '0);
        issue_request(arlt_pkg::ACT_LOOKUP, 48'h1100, '0);
        issue_request(arlt_pkg::ACT_LOOKUP, 48'h1101, '0);
        issue_request(arlt_pkg::ACT_LOOKUP, 48'h0FFF, '0);
        issue_request(arlt_pkg::ACT_RECORD, 48'h1000, 32'h10);
        issue_request(arlt_pkg::ACT_LOOKUP, 48'h1100, '0);
        issue_request(arlt_pkg::ACT_LOOKUP, 48'h1010, '0);
    endtask

    task automatic test_slot_order();
        issue_request(arlt_pkg::ACT_RECORD, 48'h1008, 32'h1000);
        issue_request(arlt_pkg::ACT_LOOKUP, 48'h1009, '0);
        issue_request(arlt_pkg::ACT_LOOKUP, 48'h1020, '0);
        issue_request(arlt_pkg::ACT_RECORD, '0, '1);
        issue_request(arlt_pkg::ACT_LOOKUP, 48'h5000, '0);
        issue_request(arlt_pkg::ACT_RECORD, '0, '0);
    endtask

    task automatic test_stalled_output();
        src_idle = 1'b0;
        sink_hold = 300;
        repeat (24) random_request(10);
        src_idle = 1'b1;
        pause_until_drained();
    endtask

    task automatic test_random_fill();
        for (int i = 0; i < 500; i++) begin
            if (i % 100 == 0) begin
                src_idle = ($urandom_range(0, 3) != 0);
                sink_idle = ($urandom_range(0, 3) != 0);
            end
            random_request(10);
        end
        src_idle = 1'b1;
        sink_idle = 1'b1;
        pause_until_drained();
    endtask

    task automatic test_full_table();
        logic [ADDR_W-1:0] base;
        while (used_count < ENTRIES) begin
            base = random_base();
            issue_request(arlt_pkg::ACT_RECORD, base, random_size());
        end
        issue_request(arlt_pkg::ACT_RECORD, ~slot_start[0], '1);
        issue_request(arlt_pkg::ACT_RECORD, slot_start[5], 32'h40);
        issue_request(arlt_pkg::ACT_LOOKUP, slot_start[5] + 48'h40, '0);
    endtask

    task automatic test_random_full();
        for (int i = 0; i < 700; i++) begin
            if (i % 100 == 0) begin
                src_idle = ($urandom_range(0, 3) != 0);
                sink_idle = ($urandom_range(0, 3) != 0);
            end
            random_request(20);
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    initial begin
        region_result_t want;
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (sink_hold > 0) begin
                m_ready <= 1'b0;
                repeat (sink_hold) @(posedge aclk);
                sink_hold = 0;
            end
            stall = sink_idle ? $urandom_range(0, 6) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                compare_field("found", want.found, m_found);
                compare_field("region_start", want.start, m_region_start);
                compare_field("region_length", want.length, m_region_length);
                compare_field("table_full", want.full, m_table_full);
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = arlt_pkg::ACT_RECORD;
        s_address = '0;
        s_alloc_size = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_lookups();
        test_extremes();
        test_same_base();
        test_slot_order();
        test_stalled_output();
        test_random_fill();
        test_full_table();
        test_random_full();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (ENTRIES + 8) @(posedge aclk);
        if (mismatches == 0)
            $display("alloc_range_lookup_table_core: match");
        else
            $display("alloc_range_lookup_table_core: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/arlt_pkg.sv
rtl/arlt_ram.sv
rtl/alloc_range_lookup_table_core.sv
rtl/arlt_checker.sv
verif/alloc_range_lookup_table_core_test.sv
